// ===== hw/rtl/fact_pkg.sv =====
// Shared types and constants for the flow anomaly counter table.
// Used by the key store, the counter store, the incrementer and the top level.
// No dependencies.
package fact_pkg;

    // Counter width. All counters saturate at all ones.
    localparam int CNT_W = 32;

    // Field widths of the input and output transactions.
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int CLASS_W = 3;
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 6;

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_TIMING = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Lookup key of one table entry.
    typedef struct packed {
        logic [ADDR_W-1:0] cli;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] srv;
    } t_flow_key;

endpackage

// ===== hw/rtl/fact_key_ram.sv =====
// Key memory of the flow table: one write port, one read port with registered data.
// Depends on fact_pkg for the key type.
module fact_key_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  fact_pkg::t_flow_key  i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output fact_pkg::t_flow_key  o_rd_data
);
    import fact_pkg::*;

    t_flow_key r_mem [DEPTH];
    t_flow_key r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered output.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/fact_ctr_ram.sv =====
// Per-entry counter memory: one write port, one read port with registered data.
// Depends on fact_pkg for the counter width.
module fact_ctr_ram #(
    parameter int DEPTH = 768,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [fact_pkg::CNT_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [fact_pkg::CNT_W-1:0] o_rd_data
);
    import fact_pkg::*;

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered output.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/fact_satinc.sv =====
// Shared saturating incrementer used for every counter update of the table.
// Depends on fact_pkg for the counter width.
module fact_satinc (
    input  logic [fact_pkg::CNT_W-1:0] i_value,
    output logic [fact_pkg::CNT_W-1:0] o_value
);
    import fact_pkg::*;

    // Hold at all ones, otherwise add one.
    assign o_value = (&i_value) ? i_value : i_value + CNT_W'(1);

endmodule

// ===== hw/rtl/flow_anomaly_counter_table.sv =====
// Flow anomaly counter table, top level. One transaction is taken at a time.
// Reset, ignored and OK events finish without a search. An anomaly reads one key per cycle
// to search the table, then updates the counter of a found entry, reports a full table,
// or inserts the key and writes every counter of the new slot.
// The next transaction is taken once the result is registered.
// Reset: synchronous, active low; empties the table and zeroes the anomaly and class totals at once.
module flow_anomaly_counter_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int CLASS_COUNT = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input stream.
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: server_addr[31:0], server_port_num[47:32], client_addr[79:48],
    //        anomaly_class[82:80], zero fill [87:83].
    input  logic [87:0]   s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [1:0]    s_axis_tuser,
    // Output stream.
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: entry_slot[5:0], entry_hits[37:6], class_total[69:38],
    //        anomaly_total[101:70], zero fill [103:102].
    output logic [103:0]  m_axis_tdata,
    // tuser: entry_used[0], table_full[1].
    output logic [1:0]    m_axis_tuser
);
    import fact_pkg::*;

    localparam int KS    = 2 * CLASS_COUNT;
    localparam int KSW   = $clog2(KS);
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IUW   = $clog2(TABLE_DEPTH + 1);
    localparam int CDEP  = TABLE_DEPTH * KS;
    localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_ANOM,
        ST_SEARCH,
        ST_CRD,
        ST_CWR,
        ST_CLEAR,
        ST_DONE
    } t_state;

    t_state            r_state;

    // Captured transaction.
    logic [CMD_W-1:0]   r_cmd;
    logic [CLASS_W-1:0] r_cls;
    logic [KSW-1:0]     r_tidx;
    t_flow_key          r_key;

    // Table and global state.
    logic [IUW-1:0]     r_in_use;
    logic [CNT_W-1:0]   r_anom;
    logic [CNT_W-1:0]   r_totals [KS];

    // Search and sweep control.
    logic [IUW-1:0]     r_idx;
    logic               r_cmp_vld;
    logic [AW-1:0]      r_cmp_idx;
    logic [KSW-1:0]     r_k;

    // Result being built.
    logic [AW-1:0]      r_slot;
    logic [CNT_W-1:0]   r_hits;
    logic [CNT_W-1:0]   r_ctot;
    logic [CNT_W-1:0]   r_atot;
    logic               r_used;
    logic               r_full;

    // Output register.
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [CNT_W-1:0]   r_out_hits;
    logic [CNT_W-1:0]   r_out_ctot;
    logic [CNT_W-1:0]   r_out_atot;
    logic               r_out_used;
    logic               r_out_full;

    // Memory and shared unit connections.
    t_flow_key          key_rd;
    logic               key_rd_en;
    logic               key_wr_en;
    logic [CNT_W-1:0]   ctr_rd;
    logic               ctr_rd_en;
    logic               ctr_wr_en;
    logic [CAW-1:0]     ctr_wr_addr;
    logic [CAW-1:0]     ctr_rd_addr;
    logic [CNT_W-1:0]   ctr_wr_data;
    logic [CNT_W-1:0]   inc_in;
    logic [CNT_W-1:0]   inc_out;

    // Decode helpers.
    t_flow_key          in_key;
    logic [CLASS_W-1:0] in_cls;
    logic [KSW-1:0]     in_tidx;
    logic               cls_bad;
    logic               key_match;
    logic               room;
    logic [AW+SLOT_W-1:0] slot_ext;
    logic [CAW-1:0]     slot_base;

    assign in_key.srv  = s_axis_tdata[31:0];
    assign in_key.port = s_axis_tdata[47:32];
    assign in_key.cli  = s_axis_tdata[79:48];
    assign in_cls      = s_axis_tdata[82:80];
    assign in_tidx     = (s_axis_tuser == CMD_COUNT)
                       ? KSW'(CLASS_COUNT) + KSW'(in_cls) : KSW'(in_cls);

    assign cls_bad   = 32'(r_cls) >= CLASS_COUNT;
    assign key_match = r_cmp_vld && (key_rd == r_key);
    assign room      = r_in_use < IUW'(TABLE_DEPTH);
    assign slot_base = CAW'(r_slot) * CAW'(KS);
    assign slot_ext  = {{SLOT_W{1'b0}}, r_slot};

    // Key memory control: reads during the search, one write on insert.
    assign key_rd_en = (r_state == ST_SEARCH) && !key_match && (r_idx < r_in_use);
    assign key_wr_en = (r_state == ST_SEARCH) && !key_match && !(r_idx < r_in_use) && room;

    // Counter memory control: clear sweep on insert, read-modify-write on a hit.
    assign ctr_rd_en   = (r_state == ST_CRD);
    assign ctr_rd_addr = slot_base + CAW'(r_tidx);
    assign ctr_wr_en   = (r_state == ST_CLEAR) || (r_state == ST_CWR);
    assign ctr_wr_addr = (r_state == ST_CLEAR) ? slot_base + CAW'(r_k) : ctr_rd_addr;
    assign ctr_wr_data = (r_state == ST_CLEAR) ? ((r_k == r_tidx) ? CNT_W'(1) : '0)
                                               : inc_out;

    // Operand of the shared incrementer follows the sequencer step.
    always_comb begin
        unique case (r_state)
            ST_TOTAL: inc_in = r_totals[r_tidx];
            ST_CWR:   inc_in = ctr_rd;
            default:  inc_in = r_anom;
        endcase
    end

    fact_satinc u_satinc (
        .i_value (inc_in),
        .o_value (inc_out)
    );

    fact_key_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr_en),
        .i_wr_addr (r_in_use[AW-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (key_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (key_rd)
    );

    fact_ctr_ram #(
        .DEPTH (CDEP),
        .AW    (CAW)
    ) u_ctr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ctr_wr_en),
        .i_wr_addr (ctr_wr_addr),
        .i_wr_data (ctr_wr_data),
        .i_rd_en   (ctr_rd_en),
        .i_rd_addr (ctr_rd_addr),
        .o_rd_data (ctr_rd)
    );

    // Sequencer, table state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_in_use    <= '0;
            r_anom      <= '0;
            for (int i = 0; i < KS; i++) begin
                r_totals[i] <= '0;
            end
        end else begin
            // The output transaction completes independently of the sequencer; a result
            // waiting in ST_DONE reloads the register in that same cycle instead.
            if (m_axis_tvalid && m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tuser;
                        r_cls   <= in_cls;
                        r_tidx  <= in_tidx;
                        r_key   <= in_key;
                        r_slot  <= '0;
                        r_hits  <= '0;
                        r_ctot  <= '0;
                        r_used  <= 1'b0;
                        r_full  <= 1'b0;
                        r_state <= ST_TOTAL;
                    end
                end

                ST_TOTAL: begin
                    priority if (r_cmd == CMD_RESET) begin
                        r_in_use <= '0;
                        r_anom   <= '0;
                        r_atot   <= '0;
                        for (int i = 0; i < KS; i++) begin
                            r_totals[i] <= '0;
                        end
                        r_state <= ST_DONE;
                    end else if (r_cmd == CMD_UNUSED || cls_bad) begin
                        r_atot  <= r_anom;
                        r_state <= ST_DONE;
                    end else begin
                        r_totals[r_tidx] <= inc_out;
                        r_ctot           <= inc_out;
                        if (r_cls == '0) begin
                            r_atot  <= r_anom;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_ANOM;
                        end
                    end
                end

                ST_ANOM: begin
                    r_anom    <= inc_out;
                    r_atot    <= inc_out;
                    r_idx     <= '0;
                    r_cmp_vld <= 1'b0;
                    r_state   <= ST_SEARCH;
                end

                // One key read issued and one compared per cycle.
                ST_SEARCH: begin
                    priority if (key_match) begin
                        r_slot  <= r_cmp_idx;
                        r_state <= ST_CRD;
                    end else if (r_idx < r_in_use) begin
                        r_cmp_idx <= r_idx[AW-1:0];
                        r_cmp_vld <= 1'b1;
                        r_idx     <= r_idx + IUW'(1);
                    end else if (room) begin
                        r_slot  <= r_in_use[AW-1:0];
                        r_k     <= '0;
                        r_state <= ST_CLEAR;
                    end else begin
                        r_full  <= 1'b1;
                        r_state <= ST_DONE;
                    end
                end

                ST_CRD: begin
                    r_state <= ST_CWR;
                end

                ST_CWR: begin
                    r_hits  <= inc_out;
                    r_used  <= 1'b1;
                    r_state <= ST_DONE;
                end

                // New entry: every counter of the slot written, the bumped one to one.
                ST_CLEAR: begin
                    if (r_k == KSW'(KS - 1)) begin
                        r_in_use <= r_in_use + IUW'(1);
                        r_hits   <= CNT_W'(1);
                        r_used   <= 1'b1;
                        r_state  <= ST_DONE;
                    end else begin
                        r_k <= r_k + KSW'(1);
                    end
                end

                // Load the output register once it is free.
                ST_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_slot  <= slot_ext[SLOT_W-1:0];
                        r_out_hits  <= r_hits;
                        r_out_ctot  <= r_ctot;
                        r_out_atot  <= r_atot;
                        r_out_used  <= r_used;
                        r_out_full  <= r_full;
                        r_state     <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_atot, r_out_ctot, r_out_hits, r_out_slot};
    assign m_axis_tuser  = {r_out_full, r_out_used};

endmodule
